// ----- hw/rtl/lif_pkg.sv -----
// shared widths, constants and command codes of the neuron layer update core
package lif_pkg;

   localparam int NEURONS = 64;
   localparam int ADDR_W  = (NEURONS > 1) ? $clog2(NEURONS) : 1;

   localparam int IDX_W   = 6;
   localparam int CUR_W   = 32;
   localparam int DECAY_W = 17;
   localparam int THR_W   = 31;
   localparam int POT_W   = 32;
   localparam int PARAM_W = DECAY_W + THR_W;

   // product of a Q16.16 potential and an unsigned Q1.16 decay
   localparam int PROD_W  = POT_W + DECAY_W;
   // product plus rounding half plus input current shifted up by 16
   localparam int SUM_W   = PROD_W + 2;
   localparam int FRAC_W  = 16;
   localparam int V_W     = SUM_W - FRAC_W;

   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);
   localparam logic [POT_W-1:0] POT_MAX    = {1'b0, {(POT_W-1){1'b1}}};
   localparam logic [POT_W-1:0] POT_MIN    = {1'b1, {(POT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_STEP  = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

endpackage

// ----- hw/rtl/lif_req_if.sv -----
// request channel: one command word per handshake
interface lif_req_if import lif_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           command;
   logic [IDX_W-1:0]     neuron_index;
   logic signed [CUR_W-1:0] input_current;
   logic [DECAY_W-1:0]   new_decay;
   logic [THR_W-1:0]     new_threshold;

   modport source (
      output valid, command, neuron_index, input_current, new_decay, new_threshold,
      input  ready
   );
   modport sink (
      input  valid, command, neuron_index, input_current, new_decay, new_threshold,
      output ready
   );
endinterface

// ----- hw/rtl/lif_rsp_if.sv -----
// response channel: one neuron result word per handshake
interface lif_rsp_if import lif_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        neuron_number;
   logic                    spike;
   logic signed [POT_W-1:0] potential;

   modport source (
      output valid, neuron_number, spike, potential,
      input  ready
   );
   modport sink (
      input  valid, neuron_number, spike, potential,
      output ready
   );
endinterface

// ----- hw/rtl/lif_ram.sv -----
// generic simple dual-port ram with registered read, old data on read-during-write
module lif_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/lif_neuron_layer_update_core.sv -----
// top level of the leaky integrate-and-fire neuron layer update core
//
// req_chan carries one command word per handshake: step a neuron with an input
// current, load a neuron's decay and threshold, or clear its potential. Only a
// step produces a word on rsp_chan: neuron number, spike flag and the new
// potential. csr_wr_en with csr_wr_data selects spiking mode (reset: on).
// Potentials live in a 64-entry ram with one valid flop per entry; decay and
// threshold share a second ram. Loads write at acceptance.
// A step's result goes through the ram read, the multiply stage and the update
// stage into the output register.
// Throughput: one word per cycle, unless a step waits or rsp_chan stalls. A step
// on a neuron that a step or clear in the multiply or update stage touches
// waits until that word's write-back, since the update stage's write-back is
// forwarded only into the read of a word accepted at that write-back.
// Reset clears all potentials to zero through the valid flops and
// sets spiking mode; decay and threshold must be loaded before a step.
// When rsp_chan stalls, the output register holds its word; the update stage
// and the multiply stage fill up behind it before req_chan.ready drops for steps and clears.
module lif_neuron_layer_update_core import lif_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lif_req_if.sink   req_chan,
   lif_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   // request decode
   logic              in_range;
   logic              is_step;
   logic              is_load;
   logic              is_clear;
   logic              is_pipe;
   logic              hazard;
   logic              accept;
   logic              pipe_accept;
   logic              load_accept;
   logic [ADDR_W-1:0] req_addr;

   // csr
   logic spiking_mode_ff;

   // potential valid flags
   logic [NEURONS-1:0] mem_vld_ff;

   // ram read data
   logic [POT_W-1:0]   mem_rdata;
   logic [PARAM_W-1:0] param_rdata;

   // multiply stage
   logic                    s1_vld_ff,  s1_vld_in;
   logic                    s1_step_ff;
   logic [IDX_W-1:0]        s1_idx_ff;
   logic signed [CUR_W-1:0] s1_cur_ff;
   logic                    s1_mvld_ff;
   logic                    s1_hit_ff,  s1_hit_in;
   logic [POT_W-1:0]        s1_hit_data_ff;
   logic                    s1_adv;
   logic                    s1_free;
   logic signed [POT_W-1:0] s1_mem;
   logic signed [DECAY_W:0] s1_decay;
   logic signed [PROD_W-1:0] prod_in;

   // update stage
   logic                     s2_vld_ff,  s2_vld_in;
   logic                     s2_step_ff;
   logic [IDX_W-1:0]         s2_idx_ff;
   logic signed [CUR_W-1:0]  s2_cur_ff;
   logic [THR_W-1:0]         s2_thr_ff;
   logic signed [PROD_W-1:0] s2_prod_ff;
   logic                     s2_fire;
   logic [ADDR_W-1:0]        s2_addr;
   logic signed [SUM_W-1:0]  sum;
   logic signed [V_W-1:0]    v_full;
   logic [POT_W-1:0]         v_sat;
   logic signed [POT_W:0]    diff;
   logic                     spike;
   logic [POT_W-1:0]         final_pot;
   logic [POT_W-1:0]         wb_data;

   // output register
   logic              out_free;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [IDX_W-1:0]  rsp_num_ff;
   logic              rsp_spike_ff;
   logic [POT_W-1:0]  rsp_pot_ff;

   // ---------------- request side ----------------
   assign in_range = (32'(req_chan.neuron_index) < NEURONS);
   assign req_addr = req_chan.neuron_index[ADDR_W-1:0];

   always_comb begin
      is_step  = 1'b0;
      is_load  = 1'b0;
      is_clear = 1'b0;
      case (req_chan.command)
         CMD_STEP:  is_step  = in_range;
         CMD_LOAD:  is_load  = in_range;
         CMD_CLEAR: is_clear = in_range;
         default: ;
      endcase
   end

   assign is_pipe = is_step | is_clear;

   // a step must see the write-back of every earlier step or clear on its neuron
   assign hazard = is_step &&
                   ((s1_vld_ff && s1_idx_ff == req_chan.neuron_index) ||
                    (s2_vld_ff && !s2_fire && s2_idx_ff == req_chan.neuron_index));

   assign req_chan.ready = is_pipe ? (s1_free && !hazard) : 1'b1;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pipe_accept    = accept && is_pipe;
   assign load_accept    = accept && is_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         spiking_mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         spiking_mode_ff <= csr_wr_data;
      end
   end

   // ---------------- memories ----------------
   lif_ram #(.WIDTH(POT_W), .DEPTH(NEURONS)) u_membrane_ram (
      .clock   (clock),
      .wr_en   (s2_fire),
      .wr_addr (s2_addr),
      .wr_data (wb_data),
      .rd_en   (pipe_accept),
      .rd_addr (req_addr),
      .rd_data (mem_rdata)
   );

   lif_ram #(.WIDTH(PARAM_W), .DEPTH(NEURONS)) u_param_ram (
      .clock   (clock),
      .wr_en   (load_accept),
      .wr_addr (req_addr),
      .wr_data ({req_chan.new_decay, req_chan.new_threshold}),
      .rd_en   (pipe_accept),
      .rd_addr (req_addr),
      .rd_data (param_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
      end else if (s2_fire) begin
         mem_vld_ff[s2_addr] <= 1'b1;
      end
   end

   // ---------------- multiply stage ----------------
   assign s1_adv  = s1_vld_ff && (!s2_vld_ff || s2_fire);
   assign s1_free = !s1_vld_ff || s1_adv;

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (pipe_accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
   end

   // write-back at the same edge as the ram read is caught here
   assign s1_hit_in = s2_fire && (s2_idx_ff == req_chan.neuron_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_accept) begin
         s1_step_ff     <= is_step;
         s1_idx_ff      <= req_chan.neuron_index;
         s1_cur_ff      <= req_chan.input_current;
         s1_mvld_ff     <= mem_vld_ff[req_addr];
         s1_hit_ff      <= s1_hit_in;
         s1_hit_data_ff <= wb_data;
      end
   end

   always_comb begin
      if (s1_hit_ff) begin
         s1_mem = s1_hit_data_ff;
      end else if (s1_mvld_ff) begin
         s1_mem = mem_rdata;
      end else begin
         s1_mem = '0;
      end
   end

   assign s1_decay = $signed({1'b0, param_rdata[PARAM_W-1:THR_W]});
   assign prod_in  = s1_mem * s1_decay;

   // ---------------- update stage ----------------
   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign s2_fire  = s2_vld_ff && (!s2_step_ff || out_free);
   assign s2_addr  = s2_idx_ff[ADDR_W-1:0];

   always_comb begin
      s2_vld_in = s2_vld_ff;
      if (s1_adv) begin
         s2_vld_in = 1'b1;
      end else if (s2_fire) begin
         s2_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_step_ff <= s1_step_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_cur_ff  <= s1_cur_ff;
         s2_thr_ff  <= param_rdata[THR_W-1:0];
         s2_prod_ff <= prod_in;
      end
   end

   // round half up, add current and shift in one sum: floor((p + 2^15 + c*2^16) / 2^16)
   assign sum = $signed({{(SUM_W-PROD_W){s2_prod_ff[PROD_W-1]}}, s2_prod_ff})
              + $signed(ROUND_HALF)
              + $signed({{(SUM_W-CUR_W-FRAC_W){s2_cur_ff[CUR_W-1]}}, s2_cur_ff,
                         {FRAC_W{1'b0}}});
   assign v_full = sum[SUM_W-1:FRAC_W];

   always_comb begin
      if (v_full[V_W-1:POT_W-1] == '0 || v_full[V_W-1:POT_W-1] == '1) begin
         v_sat = v_full[POT_W-1:0];
      end else if (v_full[V_W-1]) begin
         v_sat = POT_MIN;
      end else begin
         v_sat = POT_MAX;
      end
   end

   assign diff      = $signed({v_sat[POT_W-1], v_sat}) - $signed({2'b00, s2_thr_ff});
   assign spike     = spiking_mode_ff && !diff[POT_W] && (diff != '0);
   assign final_pot = spike ? diff[POT_W-1:0] : v_sat;
   assign wb_data   = s2_step_ff ? final_pot : '0;

   // ---------------- output register ----------------
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (s2_fire && s2_step_ff) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire && s2_step_ff) begin
         rsp_num_ff   <= s2_idx_ff;
         rsp_spike_ff <= spike;
         rsp_pot_ff   <= final_pot;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.neuron_number = rsp_num_ff;
   assign rsp_chan.spike         = rsp_spike_ff;
   assign rsp_chan.potential     = rsp_pot_ff;

   // ---------------- assertions ----------------
   // a step never shares the pipe with an unwritten update of its own neuron
   assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && s1_step_ff && s2_vld_ff |-> s1_idx_ff != s2_idx_ff)
      else $error("step in multiply stage overlaps pending write of same neuron");

   // a new result word only comes from a step leaving the update stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s2_fire && s2_step_ff))
      else $error("result word appeared without a step");

   // a spike leaves a strictly positive potential
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_spike_ff |-> !rsp_pot_ff[POT_W-1] && rsp_pot_ff != '0)
      else $error("spike with non-positive potential");

   // no spike may be reported in non-spiking mode
   assert property (@(posedge clock) disable iff (reset)
      s2_fire && s2_step_ff && !spiking_mode_ff |=> !rsp_spike_ff)
      else $error("spike reported in non-spiking mode");

endmodule
